[rtl/char_lcd_request_sequencer_unit_macros.svh]
// assertion macros shared by the checker
`ifndef CHAR_LCD_REQUEST_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_REQUEST_SEQUENCER_UNIT_MACROS_SVH

`define CLRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define CLRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/clrs_pkg.sv]
// ----------------------------------------------------------------------------
// clrs_pkg
// types and constants of the character lcd request sequencer
// ----------------------------------------------------------------------------
`default_nettype none
package clrs_pkg;
   localparam int QueueSlots   = 13;
   localparam int MaxDigits    = 10;
   localparam int PowerOnTicks = 15;
   localparam int SlotBits     = $clog2(QueueSlots);
   localparam int FifoDepth    = 2;

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_INIT   = 3'd1;
   localparam logic [2:0] CMD_CURSOR = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_NUMBER = 3'd4;

   localparam logic [7:0] LCD_FUNC  = 8'h38;
   localparam logic [7:0] LCD_DISP  = 8'h0F;
   localparam logic [7:0] LCD_CLR   = 8'h01;
   localparam logic [7:0] LCD_ROW1  = 8'h40;
   localparam logic [7:0] LCD_DDRAM = 8'd128;
   localparam logic [7:0] ASCII_0   = 8'h30;

   typedef enum logic [1:0] {PH_OFF, PH_INIT, PH_OPER} phase_type;
   typedef enum logic [2:0] {IS_WAIT, IS_FUNC, IS_DISP, IS_CLEAR, IS_END} init_type;
   typedef enum logic [1:0] {K_NONE, K_CURSOR, K_CLEAR, K_NUMBER} kind_type;
   typedef enum logic [1:0] {FS_IDLE, FS_CONV, FS_PUSH} front_state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  row;
      logic [5:0]  column;
      logic [31:0] number;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       lcd_rs;
      logic       lcd_en;
      logic [7:0] lcd_data;
      logic       ready_res;
   } rsp_type;

   // classified beat from front to back
   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  command;
      logic [39:0] digits;
      logic [3:0]  length;
   } job_type;
endpackage
`default_nettype wire

[rtl/clrs_front.sv]
// ----------------------------------------------------------------------------
// clrs_front
// accepts requests, builds slot commands and decimal digits one per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module clrs_front import clrs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         job_valid,
   input  wire logic    job_stall,
   output job_type      job_data
);
   front_state_type state_ff, state_in;
   req_type     req_ff, req_in;
   logic [31:0] num_ff, num_in;
   logic [39:0] dig_ff, dig_in;
   logic [3:0]  len_ff, len_in;
   logic [31:0] quot;
   logic [3:0]  rem;
   logic [63:0] prod;
   logic [7:0]  loc;

   // divide by ten through reciprocal multiply, exact over 32 bits
   always_comb begin
      prod = 64'(num_ff) * 64'h0000_0000_CCCC_CCCD;
      quot = {3'b000, prod[63:35]};
      rem  = 4'(num_ff - {quot[28:0], 3'b000} - {quot[30:0], 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FS_IDLE;
      else state_ff <= state_in;
      req_ff <= req_in;
      num_ff <= num_in;
      dig_ff <= dig_in;
      len_ff <= len_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      num_in    = num_ff;
      dig_in    = dig_ff;
      len_in    = len_ff;
      req_stall = (state_ff != FS_IDLE);
      job_valid = (state_ff == FS_PUSH);
      unique case (state_ff)
         FS_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               num_in = req_data.number;
               dig_in = '0;
               len_in = '0;
               if (req_data.cmd == CMD_NUMBER) begin
                  state_in = FS_CONV;
                  if (req_data.number == '0) len_in = 4'd2;
               end else state_in = FS_PUSH;
            end
         end
         FS_CONV: begin
            if (num_ff == '0 || len_ff == 4'(MaxDigits)) state_in = FS_PUSH;
            else begin
               dig_in = dig_ff | (40'(rem) << {len_ff, 2'b00});
               num_in = quot;
               len_in = len_ff + 4'd1;
            end
         end
         FS_PUSH: if (!job_stall) state_in = FS_IDLE;
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      priority case (req_ff.row)
         2'd0: loc = {2'b00, req_ff.column};
         2'd1: loc = {2'b00, req_ff.column} + LCD_ROW1;
         default: loc = '0;
      endcase
      job_data.cmd     = req_ff.cmd;
      job_data.command = (req_ff.cmd == CMD_CLEAR) ? LCD_CLR : LCD_DDRAM + loc;
      job_data.digits  = dig_ff;
      job_data.length  = len_ff;
   end
endmodule
`default_nettype wire

[rtl/clrs_fifo.sv]
// ----------------------------------------------------------------------------
// clrs_fifo
// short queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module clrs_fifo import clrs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire job_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output job_type      out_data
);
   job_type    mem_ff [FifoDepth];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'(FifoDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

[rtl/clrs_back.sv]
// ----------------------------------------------------------------------------
// clrs_back
// slot table, init sequence and bus drive; one beat out per job
// ----------------------------------------------------------------------------
`default_nettype none
module clrs_back import clrs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_stall,
   input  wire job_type job_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   phase_type   phase_ff, phase_in;
   init_type    step_ff, step_in;
   logic [3:0]  wait_ff, wait_in;
   logic        en_ff, en_in, rs_ff, rs_in;
   logic [7:0]  bus_ff, bus_in;
   kind_type    kind_ff [QueueSlots];
   logic [7:0]  cmdb_ff [QueueSlots];
   logic [39:0] digs_ff [QueueSlots];
   logic [3:0]  len_ff  [QueueSlots];
   logic [SlotBits-1:0] idx_ff, idx_in;
   logic [3:0]  pos_ff, pos_in;
   logic        ov_ff, ov_in;
   rsp_type     out_ff, out_in;
   // search state
   logic        srch_ff, srch_in;
   logic [SlotBits-1:0] sp_ff, sp_in;
   logic        free_found;
   logic        fire, wr, rel;
   logic [SlotBits-1:0] rel_idx;
   kind_type    wr_kind;
   kind_type    ck;
   logic [3:0]  cl, rdig;
   logic [39:0] cd;
   logic        lastslot;

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
   assign free_found = (kind_ff[sp_ff] == K_NONE);
   assign lastslot = (sp_ff == SlotBits'(QueueSlots - 1));
   assign ck = kind_ff[idx_ff];
   assign cl = len_ff[idx_ff];
   assign cd = digs_ff[idx_ff];
   assign rdig = 4'(cd >> {cl - pos_ff - 4'd1, 2'b00});

   // stall while a result waits or the slot scan runs
   always_comb begin
      logic is_req;
      is_req = (job_data.cmd == CMD_CURSOR) || (job_data.cmd == CMD_CLEAR) ||
               (job_data.cmd == CMD_NUMBER);
      job_stall = (ov_ff && rsp_stall) || (is_req && !(srch_ff &&
                  (free_found || lastslot)));
      fire = job_valid && !job_stall;
      srch_in = srch_ff; sp_in = sp_ff;
      if (job_valid && is_req && !(ov_ff && rsp_stall)) begin
         if (!srch_ff) begin
            srch_in = 1'b1; sp_in = '0;
         end else if (free_found || lastslot) srch_in = 1'b0;
         else sp_in = sp_ff + 1'b1;
      end
      wr = fire && is_req && free_found;
      unique case (job_data.cmd)
         CMD_CURSOR: wr_kind = K_CURSOR;
         CMD_CLEAR:  wr_kind = K_CLEAR;
         default:    wr_kind = K_NUMBER;
      endcase
   end

   always_comb begin
      phase_in = phase_ff; step_in = step_ff; wait_in = wait_ff;
      en_in = en_ff; rs_in = rs_ff; bus_in = bus_ff;
      idx_in = idx_ff; pos_in = pos_ff; rel = 1'b0; rel_idx = idx_ff;
      ov_in = ov_ff && rsp_stall;
      out_in = out_ff;
      if (fire) begin
         if (job_data.cmd == CMD_INIT) phase_in = PH_INIT;
         else if (job_data.cmd == CMD_TICK && phase_ff == PH_INIT) begin
            unique case (step_ff)
               IS_WAIT: begin
                  wait_in = wait_ff + 4'd1;
                  if (wait_in == 4'(PowerOnTicks)) begin
                     wait_in = '0; step_in = IS_FUNC;
                  end
               end
               IS_FUNC, IS_DISP, IS_CLEAR: begin
                  if (!en_ff) begin
                     rs_in = 1'b0; en_in = 1'b1;
                     bus_in = (step_ff == IS_FUNC) ? LCD_FUNC :
                              (step_ff == IS_DISP) ? LCD_DISP : LCD_CLR;
                  end else begin
                     en_in = 1'b0;
                     step_in = (step_ff == IS_FUNC) ? IS_DISP :
                               (step_ff == IS_DISP) ? IS_CLEAR : IS_END;
                  end
               end
               default: phase_in = PH_OPER;
            endcase
         end else if (job_data.cmd == CMD_TICK && phase_ff == PH_OPER) begin
            unique case (ck)
               K_CURSOR, K_CLEAR: begin
                  if (!en_ff) begin
                     rs_in = 1'b0; en_in = 1'b1; bus_in = cmdb_ff[idx_ff];
                  end else begin
                     en_in = 1'b0; rel = 1'b1;
                  end
               end
               K_NUMBER: begin
                  if (pos_ff < cl && cl <= 4'(MaxDigits)) begin
                     if (!en_ff) begin
                        rs_in = 1'b1; en_in = 1'b1; bus_in = ASCII_0 + 8'(rdig);
                     end else begin
                        en_in = 1'b0; pos_in = pos_ff + 4'd1;
                     end
                  end else begin
                     rel = 1'b1; pos_in = '0;
                  end
               end
               default: idx_in = '0;
            endcase
            if (rel) idx_in = (idx_ff == SlotBits'(QueueSlots - 1)) ? '0 : idx_ff + 1'b1;
         end
         ov_in = 1'b1;
         out_in.accepted  = wr;
         out_in.lcd_rs    = rs_in;
         out_in.lcd_en    = en_in;
         out_in.lcd_data  = bus_in;
         out_in.ready_res = (phase_in == PH_OPER);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OFF; step_ff <= IS_WAIT; wait_ff <= '0;
         en_ff <= 1'b0; rs_ff <= 1'b0; bus_ff <= '0;
         idx_ff <= '0; pos_ff <= '0; ov_ff <= 1'b0;
         srch_ff <= 1'b0; sp_ff <= '0;
         for (int i = 0; i < QueueSlots; i++) kind_ff[i] <= K_NONE;
      end else begin
         phase_ff <= phase_in; step_ff <= step_in; wait_ff <= wait_in;
         en_ff <= en_in; rs_ff <= rs_in; bus_ff <= bus_in;
         idx_ff <= idx_in; pos_ff <= pos_in; ov_ff <= ov_in;
         srch_ff <= srch_in; sp_ff <= sp_in;
         if (rel) kind_ff[rel_idx] <= K_NONE;
         if (wr) kind_ff[sp_ff] <= wr_kind;
      end
      out_ff <= out_in;
      if (wr) begin
         cmdb_ff[sp_ff] <= job_data.command;
         digs_ff[sp_ff] <= job_data.digits;
         len_ff[sp_ff]  <= job_data.length;
      end
   end
endmodule
`default_nettype wire

[rtl/char_lcd_request_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_request_sequencer_unit
// hd44780-style 8-bit lcd controller with a request slot table
// ----------------------------------------------------------------------------
// Every request beat yields one response beat with the bus pins after it.
// A write-number request spends time in the front on the decimal
// conversion (one digit per cycle); a slot request then waits in the back
// for the free-slot scan (one slot per cycle unless a response is stalled).
`default_nettype none
module char_lcd_request_sequencer_unit import clrs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   logic    fv, fs, bv, bs;
   job_type fd, bd;

   clrs_front u_front (.clock, .reset, .req_valid, .req_stall, .req_data,
      .job_valid(fv), .job_stall(fs), .job_data(fd));
   clrs_fifo u_fifo (.clock, .reset, .in_valid(fv), .in_stall(fs), .in_data(fd),
      .out_valid(bv), .out_stall(bs), .out_data(bd));
   clrs_back u_back (.clock, .reset, .job_valid(bv), .job_stall(bs), .job_data(bd),
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule
`default_nettype wire

[rtl/clrs_checker.sv]
// ----------------------------------------------------------------------------
// clrs_checker
// port-level checks of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none
`include "char_lcd_request_sequencer_unit_macros.svh"
module clrs_checker import clrs_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   `CLRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "response changed while stalled")
   `CLRS_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_data), "request changed while stalled")
   `CLRS_ASSERT_NEXT(a_first_idle, clock, reset, $past(reset),
      !rsp_valid, "response right after reset")
endmodule
bind char_lcd_request_sequencer_unit clrs_checker u_chk (.*);
`default_nettype wire
